[rtl/ipd_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ipd_pkg: shared definitions for the integer power unit
// Default widths, multiplier chunk width and sequencer state type.
// ----------------------------------------------------------------------------
package ipd_pkg;

	// default data and exponent widths
	localparam int DATA_BITS_DEF = 32;
	localparam int EXP_BITS_DEF  = 16;

	// operand chunk width of the shared multiplier
	localparam int MUL_BITS = 32;

	// sequencer states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_WAIT
	} ipd_state_t;

endpackage : ipd_pkg
`default_nettype wire

[rtl/ipd_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ipd_if: stream channels of the integer power unit
// Input channel carries base and exponent, output channel carries power.
// ----------------------------------------------------------------------------
interface ipd_in_if #(
	parameter int DATA_BITS = 32,
	parameter int EXP_BITS  = 16
);
	logic                        valid;
	logic                        ready;
	logic signed [DATA_BITS-1:0] base;
	logic        [EXP_BITS-1:0]  exponent;

	modport source (output valid, output base, output exponent, input ready);
	modport sink   (input valid, input base, input exponent, output ready);
endinterface : ipd_in_if

interface ipd_out_if #(
	parameter int DATA_BITS = 32
);
	logic                        valid;
	logic                        ready;
	logic signed [DATA_BITS-1:0] power;

	modport source (output valid, output power, input ready);
	modport sink   (input valid, input power, output ready);
endinterface : ipd_out_if
`default_nettype wire

[rtl/ipd_mul.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ipd_mul: shared truncating multiplier
// Returns the low DATA_BITS bits of a * b. Operands are split into MUL_BITS
// chunks; one chunk product is accumulated per cycle, skipping products that
// land above the kept width. At DATA_BITS <= MUL_BITS a product is a single
// chunk product and busy never rises.
// ----------------------------------------------------------------------------
module ipd_mul import ipd_pkg::*; #(
	parameter int DATA_BITS = DATA_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [DATA_BITS-1:0] a,
	input  logic [DATA_BITS-1:0] b,
	output logic                 busy,
	output logic [DATA_BITS-1:0] prod
);

	localparam int NCH = (DATA_BITS + MUL_BITS - 1) / MUL_BITS;
	localparam int PAD = NCH * MUL_BITS;
	localparam int CW  = (NCH > 1) ? $clog2(NCH) : 1;
	localparam int SW  = $clog2(PAD) + 1;

	logic [DATA_BITS-1:0]  a_q, b_q, acc_q;
	logic [CW-1:0]         i_q, j_q;
	logic                  busy_q;

	logic [DATA_BITS-1:0]  op_a, op_b;
	logic [PAD-1:0]        a_pad, b_pad;
	logic [MUL_BITS-1:0]   a_chunk, b_chunk;
	logic [2*MUL_BITS-1:0] pp;
	logic [PAD-1:0]        pp_ext;
	logic [CW-1:0]         cur_i, cur_j;
	logic [CW:0]           ij_sum;
	logic [SW-1:0]         sh;
	logic                  issue, last;
	logic [CW-1:0]         nxt_i, nxt_j;
	logic [DATA_BITS-1:0]  acc_d;

	// select the chunk pair for this cycle
	always_comb begin
		cur_i   = start ? '0 : i_q;
		cur_j   = start ? '0 : j_q;
		op_a    = start ? a : a_q;
		op_b    = start ? b : b_q;
		a_pad   = PAD'(op_a);
		b_pad   = PAD'(op_b);
		a_chunk = a_pad[cur_i*MUL_BITS +: MUL_BITS];
		b_chunk = b_pad[cur_j*MUL_BITS +: MUL_BITS];
		ij_sum  = {1'b0, cur_i} + {1'b0, cur_j};
		sh      = SW'(ij_sum) << $clog2(MUL_BITS);
		issue   = start || busy_q;
		last    = (cur_i == CW'(NCH - 1)) && (cur_j == '0);
	end

	// multiply one chunk pair and align it
	always_comb begin
		pp     = a_chunk * b_chunk;
		pp_ext = PAD'(pp) << sh;
		acc_d  = (start ? '0 : acc_q) + DATA_BITS'(pp_ext);
	end

	// advance to the next pair below the kept width
	always_comb begin
		if (ij_sum + 1'b1 < (CW+1)'(NCH)) begin
			nxt_i = cur_i;
			nxt_j = cur_j + 1'b1;
		end else begin
			nxt_i = cur_i + 1'b1;
			nxt_j = '0;
		end
	end

	// sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			i_q    <= '0;
			j_q    <= '0;
		end else begin
			busy_q <= issue && !last;
			if (issue) begin
				i_q <= nxt_i;
				j_q <= nxt_j;
			end
		end
	end

	// hold operands and accumulate
	always_ff @(posedge clk) begin
		if (start) begin
			a_q <= a;
			b_q <= b;
		end
		if (issue) begin
			acc_q <= acc_d;
		end
	end

	assign busy = busy_q;
	assign prod = acc_q;

endmodule : ipd_mul
`default_nettype wire

[rtl/integer_power_by_doubling.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// integer_power_by_doubling: base raised to an unsigned exponent
// Computes base^exponent wrapped to DATA_BITS-bit two's complement by squaring
// up to the largest power of two not above the exponent, then multiplying by
// the base once per remaining step.
// - in_ch carries base and exponent; ready is high only while idle, so one
//   item is in work at a time.
// - out_ch carries power, one result per input item, from an output register.
// - A zero base (0) or a zero exponent (1) skips the multiplier: the result
//   goes through res_q in ST_WAIT into the output register.
// - Otherwise, with k = floor(log2(e)), the sequencer runs k squarings and then
//   e - 2^k multiplications by the base. At DATA_BITS <= 32 the shared
//   multiplier gives one product per cycle; wider data is split into NCH 32-bit
//   chunks and accumulates the chunk products that land within the kept width.
// - The next item is taken the cycle after the result loads into the output
//   register, so a new item is never taken before the last result has loaded.
// - If the receiver stalls, the result holds in the output register and the
//   next result waits in the sequencer until that register frees.
// - Reset clears the sequencer and output valid; no result is pending after.
// ----------------------------------------------------------------------------
module integer_power_by_doubling import ipd_pkg::*; #(
	parameter int DATA_BITS = DATA_BITS_DEF,
	parameter int EXP_BITS  = EXP_BITS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	ipd_in_if.sink    in_ch,
	ipd_out_if.source out_ch
);

	ipd_state_t           state_q, state_d;
	logic [DATA_BITS-1:0] base_q;
	logic [EXP_BITS-1:0]  exp_q;
	logic [EXP_BITS-1:0]  r_q, r_d;
	logic                 first_q, first_d;
	logic [DATA_BITS-1:0] res_q, res_d;
	logic                 out_valid_q;
	logic [DATA_BITS-1:0] power_q;

	logic                 take_in, out_load;
	logic                 mul_start, mul_busy;
	logic [DATA_BITS-1:0] mul_a, mul_b, mul_prod;
	logic [DATA_BITS-1:0] cur;
	logic [EXP_BITS:0]    twice_r;

	ipd_mul #(
		.DATA_BITS (DATA_BITS)
	) u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.a      (mul_a),
		.b      (mul_b),
		.busy   (mul_busy),
		.prod   (mul_prod)
	);

	assign cur     = first_q ? base_q : mul_prod;
	assign twice_r = {r_q, 1'b0};

	// next state and sequencing
	always_comb begin
		state_d   = state_q;
		r_d       = r_q;
		first_d   = first_q;
		res_d     = res_q;
		take_in   = 1'b0;
		out_load  = 1'b0;
		mul_start = 1'b0;
		mul_a     = cur;
		mul_b     = cur;
		case (state_q)
			ST_IDLE: begin
				take_in = in_ch.valid;
				if (in_ch.valid) begin
					if (in_ch.base == '0) begin
						res_d   = '0;
						state_d = ST_WAIT;
					end else if (in_ch.exponent == '0) begin
						res_d   = DATA_BITS'(1);
						state_d = ST_WAIT;
					end else begin
						r_d     = EXP_BITS'(1);
						first_d = 1'b1;
						state_d = ST_RUN;
					end
				end
			end
			ST_RUN: begin
				if (!mul_busy) begin
					if (twice_r <= {1'b0, exp_q}) begin
						mul_start = 1'b1;
						r_d       = twice_r[EXP_BITS-1:0];
						first_d   = 1'b0;
					end else if (r_q < exp_q) begin
						mul_start = 1'b1;
						mul_b     = base_q;
						r_d       = r_q + 1'b1;
						first_d   = 1'b0;
					end else begin
						res_d   = cur;
						state_d = ST_WAIT;
					end
				end
			end
			ST_WAIT: begin
				out_load = !out_valid_q || out_ch.ready;
				if (out_load) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			first_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			first_q <= first_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (take_in) begin
			base_q <= in_ch.base;
			exp_q  <= in_ch.exponent;
		end
		r_q   <= r_d;
		res_q <= res_d;
		if (out_load) begin
			power_q <= res_q;
		end
	end

	assign in_ch.ready  = (state_q == ST_IDLE);
	assign out_ch.valid = out_valid_q;
	assign out_ch.power = power_q;

`ifndef SYNTHESIS
	// the shared multiplier is never mid-product while idle
	a_mul_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> !mul_busy)
		else $error("multiplier busy while idle");

	// the reached exponent never passes the target
	a_r_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RUN) |-> (r_q <= exp_q))
		else $error("reached exponent above target");

	// an input transfer closes the input side for the next cycle
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		(in_ch.valid && in_ch.ready) |=> !in_ch.ready)
		else $error("second item taken while busy");
`endif

endmodule : integer_power_by_doubling
`default_nettype wire
